/* rtl/sha_pkg.sv */
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int BLK_BYTES = 64;
    localparam int ROUNDS    = 64;
    localparam logic [0:0] OP_ABSORB = 1'b0;
    localparam logic [0:0] OP_FINISH = 1'b1;

    typedef logic [31:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    // control from sequencer to compression core
    typedef struct packed {
        logic       start;
        logic       step;
        logic [5:0] rnd;
    } core_ctl_t;

    function automatic word_t round_k(input logic [5:0] i);
        word_t k;
        case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t init_h(input logic [2:0] i);
        word_t h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* rtl/sha_if.sv */
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// Valid/ready channels carrying input words and digest words.
// ----------------------------------------------------------------------------
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;
    modport source (output valid, operation, data_byte, input ready);
    modport sink (input valid, operation, data_byte, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* rtl/sha_ram.sv */
// ----------------------------------------------------------------------------
// sha_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/sha_core.sv */
// ----------------------------------------------------------------------------
// sha_core
// One SHA-256 round per step, message schedule in a 16-word window.
// ----------------------------------------------------------------------------
module sha_core (
    input  logic               clk,
    input  sha_pkg::core_ctl_t ctl,
    input  sha_pkg::word_t     w_in,
    input  logic [255:0]       h_in,
    output logic [255:0]       v_out
);
    import sha_pkg::*;

    word_t v_reg [8];
    word_t w_reg [16];
    word_t wt, s0, s1, t1, t2, e, a, wn;

    // schedule word for this round
    always_comb
    begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wn = w_reg[0] + s0 + w_reg[9] + s1;
        wt = (ctl.rnd < 6'd16) ? w_in : wn;
        e  = v_reg[4];
        a  = v_reg[0];
        t1 = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
           + ((e & v_reg[5]) ^ (~e & v_reg[6])) + round_k(ctl.rnd) + wt;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
           + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // working variables and schedule window
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_in[255 - 32*i -: 32];
            end
        end
        else if (ctl.step)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= e;
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= a;
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wt;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            v_out[255 - 32*i -: 32] = v_reg[i];
        end
    end
endmodule

/* rtl/sha256_byte_stream_hasher_top.sv */
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_top
// SHA-256 over a byte stream with digest output as eight 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: one word per message byte (operation absorb) or a finish
//   word (operation finish, data_byte ignored).
//   out channel: eight digest words per finish, index 0 first, last_word on 7.
//   An absorb word is taken while idle; when it fills the 64-byte buffer
//   the input is held off for the compression: a load state, 16 rounds
//   during which the byte-wide buffer RAM read port assembles each
//   schedule word byte by byte, 48 rounds at one per cycle and an add state
//   that adds into the chaining words.
//   A finish writes the padding one byte per cycle into the buffer RAM
//   and runs one compression, or two with a second padding block written
//   between them.
//   Reset loads the initial chaining words and clears length and fill count;
//   the buffer RAM is not cleared. While the receiver stalls, the digest word
//   holds and no new input word is taken. After the last word the block is
//   ready for the next message with initial values.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_top (
    input logic clk,
    input logic rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    import sha_pkg::*;

    state_t       state_reg, state_next;
    word_t        h_reg [8];
    logic [63:0]  len_reg, len_next;
    logic [5:0]   fill_reg, fill_next;
    logic [6:0]   pad_reg, pad_next;     // padding write position
    logic         fin_reg, fin_next;     // finishing message
    logic [5:0]   rnd_reg, rnd_next;
    logic [1:0]   bsel_reg, bsel_next;   // byte within fetched word
    logic [2:0]   oidx_reg, oidx_next;
    word_t        wacc_reg, wacc_next;
    logic         add_en, h_reset;

    logic         ram_we;
    logic [5:0]   ram_waddr, ram_raddr;
    logic [7:0]   ram_wdata, ram_rdata;
    core_ctl_t    ctl;
    logic [255:0] h_flat, v_flat;
    logic [63:0]  bits;

    sha_ram #(.WIDTH(8), .DEPTH(BLK_BYTES)) u_buf (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    sha_core u_core (.clk(clk), .ctl(ctl), .w_in(wacc_next), .h_in(h_flat), .v_out(v_flat));

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            h_flat[255 - 32*i -: 32] = h_reg[i];
        end
    end

    assign bits = {len_reg[60:0], 3'b000};

    // sequencer: absorb, padding, fetch/round loop, digest output
    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        fill_next   = fill_reg;
        pad_next    = pad_reg;
        fin_next    = fin_reg;
        rnd_next    = rnd_reg;
        bsel_next   = bsel_reg;
        oidx_next   = oidx_reg;
        wacc_next   = wacc_reg;
        ram_we      = 1'b0;
        ram_waddr   = fill_reg;
        ram_wdata   = in_ch.data_byte;
        ram_raddr   = {rnd_reg[3:0], bsel_reg};
        ctl         = '{start: 1'b0, step: 1'b0, rnd: rnd_reg};
        add_en      = 1'b0;
        h_reset     = 1'b0;
        in_ch.ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    if (in_ch.operation == OP_ABSORB)
                    begin
                        ram_we    = 1'b1;
                        len_next  = len_reg + 64'd1;
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            state_next = ST_LOAD;
                            fin_next   = 1'b0;
                        end
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = 8'h80;
                        pad_next   = {1'b0, fill_reg} + 7'd1;
                        fin_next   = 1'b1;
                        state_next = ST_PAD;
                    end
                end
                ctl.start = 1'b1;
                rnd_next  = '0;
                bsel_next = '0;
            end
            ST_PAD:
            begin
                // zero fill then length, or compress a full first pad block
                if (pad_reg == 7'd64)
                begin
                    pad_next   = {1'b0, pad_reg[5:0]};
                    state_next = ST_LOAD;
                    fill_next  = 6'd63; // marks a leading pad block
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pad_reg[5:0];
                    if (fill_reg < 6'd56 || fill_reg == 6'd63)
                    begin
                        ram_wdata = (pad_reg >= 7'd56)
                                  ? bits[8*(7'd63 - pad_reg) +: 8] : 8'h00;
                    end
                    else
                    begin
                        ram_wdata = 8'h00;
                    end
                    pad_next = pad_reg + 7'd1;
                    if (pad_reg == 7'd63 && (fill_reg < 6'd56 || fill_reg == 6'd63))
                    begin
                        state_next = ST_LOAD;
                        fill_next  = '0;
                    end
                end
                ctl.start = 1'b1;
                rnd_next  = '0;
                bsel_next = '0;
            end
            ST_LOAD:
            begin
                // issue the read of the first byte of the first schedule word
                bsel_next  = bsel_reg + 2'd1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (rnd_reg < 6'd16)
                begin
                    // byte read pipeline: one byte arrives per cycle
                    wacc_next = {wacc_reg[23:0], ram_rdata};
                    if (bsel_reg == 2'd0)
                    begin
                        ctl.step  = 1'b1;
                        rnd_next  = rnd_reg + 6'd1;
                        // first byte of the following schedule word
                        ram_raddr = {rnd_reg[3:0] + 4'd1, 2'b00};
                    end
                    else
                    begin
                        wacc_next = {wacc_reg[23:0], ram_rdata};
                    end
                    bsel_next = bsel_reg + 2'd1;
                    if (bsel_reg == 2'd0 && rnd_reg == 6'd15)
                    begin
                        bsel_next = '0;
                    end
                end
                else
                begin
                    ctl.step = 1'b1;
                    rnd_next = rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                    begin
                        state_next = ST_ADD;
                    end
                end
            end
            ST_ADD:
            begin
                add_en = 1'b1;
                if (fin_reg && fill_reg == 6'd63)
                begin
                    // second pad block: zeros up to length
                    fill_next  = 6'd0;
                    pad_next   = 7'd0;
                    state_next = ST_PAD;
                end
                else if (fin_reg)
                begin
                    oidx_next  = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    fill_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        h_reset    = 1'b1;
                        len_next   = '0;
                        fill_next  = '0;
                        fin_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_ch.valid       = (state_reg == ST_OUT);
    assign out_ch.digest_word = h_reg[oidx_reg];
    assign out_ch.word_index  = oidx_reg;
    assign out_ch.last_word   = (oidx_reg == 3'd7);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            len_reg    <= '0;
            fill_reg   <= '0;
            pad_reg    <= '0;
            fin_reg    <= 1'b0;
            rnd_reg    <= '0;
            bsel_reg   <= '0;
            oidx_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            fill_reg   <= fill_next;
            pad_reg    <= pad_next;
            fin_reg    <= fin_next;
            rnd_reg    <= rnd_next;
            bsel_reg   <= bsel_next;
            oidx_reg   <= oidx_next;
        end
    end

    // chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_h(3'(i));
            end
        end
        else if (h_reset)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_h(3'(i));
            end
        end
        else if (add_en)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_flat[255 - 32*i -: 32];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wacc_reg <= wacc_next;
    end

    // input is taken only while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == ST_IDLE)
        else $error("input taken outside idle");

    // last word leaves the output state
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.last_word) |=> state_reg == ST_IDLE)
        else $error("digest did not end");

    // rounds advance only during compression
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step |-> state_reg == ST_ROUND)
        else $error("round step outside compression");
endmodule
